/* hdl/pklt_pkg.sv */
`default_nettype none
package pklt_pkg;
  localparam int IN_BYTES  = 18;
  localparam int OUT_BYTES = 23;

  localparam logic [2:0] FN_TICK  = 3'd0;
  localparam logic [2:0] FN_ADD   = 3'd1;
  localparam logic [2:0] FN_RM    = 3'd2;
  localparam logic [2:0] FN_PONG  = 3'd3;
  localparam logic [2:0] FN_START = 3'd4;
  localparam logic [2:0] FN_STOP  = 3'd5;

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_PING = 2'd1;
  localparam logic [1:0] KIND_ACC  = 2'd2;
  localparam logic [1:0] KIND_REJ  = 2'd3;

  localparam logic [1:0] REG_INTERVAL = 2'd0;
  localparam logic [1:0] REG_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_LIMIT    = 2'd2;
  localparam logic [1:0] REG_MAXACT   = 2'd3;

  typedef struct packed {
    logic load;
    logic walk;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic ping_left;
    logic out_free;
  } stat_t;
endpackage
`default_nettype wire

/* hdl/pklt_ctrl.sv */
`default_nettype none
module pklt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire pklt_pkg::stat_t stat,
  output pklt_pkg::cmd_t       cmd
);
  import pklt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (stat.walk_done) begin
          cmd.finish = 1'b1;
          state_next = ST_EMIT;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (!stat.ping_left) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == ST_IDLE) else $error("load outside idle");
  a_emit_state: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> state == ST_EMIT) else $error("emit outside emit state");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.walk, cmd.finish, cmd.emit})) else $error("command clash");
endmodule
`default_nettype wire

/* hdl/pklt_dp.sv */
`default_nettype none
module pklt_dp #(
  parameter int SLOTS = 16,
  parameter int NB    = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [31:0]            cfg_data,
  input  wire logic [pklt_pkg::IN_BYTES*8-1:0] s_tdata,
  input  wire logic [2:0]             s_tuser,
  input  wire pklt_pkg::cmd_t         cmd,
  output pklt_pkg::stat_t             stat,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [pklt_pkg::OUT_BYTES*8-1:0] m_tdata,
  output logic [1:0]                  m_tuser,
  output logic                        m_tlast
);
  import pklt_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // config
  logic [31:0] interval, timeout;
  logic [7:0]  limit;
  logic [4:0]  max_act;

  // table
  logic [31:0]   t_ip   [SLOTS];
  logic [15:0]   t_port [SLOTS];
  logic [NB-1:0] t_non  [SLOTS];
  logic [31:0]   t_ping [SLOTS];
  logic [31:0]   t_pong [SLOTS];
  logic [7:0]    t_miss [SLOTS];
  logic          t_pend [SLOTS];

  logic [CW-1:0] count, rd, wr;
  logic          running;
  logic [31:0]   last_batch, pings, pongs;

  // latched item
  logic [2:0]    func;
  logic [31:0]   now, ip;
  logic [15:0]   port;
  logic [NB-1:0] nonce;
  logic          go, walk_en, flag;

  // input unpack
  logic [31:0]   in_now, in_ip;
  logic [15:0]   in_port;
  logic [NB-1:0] in_nonce;
  assign in_now   = s_tdata[31:0];
  assign in_ip    = s_tdata[63:32];
  assign in_port  = s_tdata[79:64];
  assign in_nonce = s_tdata[80 +: NB];

  logic in_tick_go, in_pong_go;
  assign in_tick_go = running && ((in_now - last_batch) >= interval);
  assign in_pong_go = running && (in_ip != '0) && (in_port != '0) && (in_nonce != '0);

  // entry under the read pointer
  logic [IW-1:0] ri, wi, ci;
  assign ri = rd[IW-1:0];
  assign wi = wr[IW-1:0];
  assign ci = count[IW-1:0];

  logic       silent, drop, pmatch, kmatch, add_ok, rd_end;
  logic [7:0] miss_inc;
  assign rd_end   = (rd == count);
  assign silent   = (now - t_pong[ri]) > timeout;
  assign miss_inc = (t_miss[ri] == 8'hFF) ? 8'hFF : t_miss[ri] + 8'd1;
  assign drop     = silent && (miss_inc >= limit);
  assign kmatch   = (t_ip[ri] == ip) && (t_port[ri] == port);
  assign pmatch   = (t_ip[ri] == ip) && t_pend[ri] && (t_non[ri] == nonce) &&
                    ((now - t_ping[ri]) <= timeout);
  assign add_ok   = !flag && (ip != '0) && (port != '0) &&
                    ({3'b0, count} < {3'b0, max_act}) && (count < CW'(SLOTS));

  assign stat.walk_done = !walk_en || rd_end;
  assign stat.ping_left = (func == FN_TICK) && go && !rd_end;
  assign stat.out_free  = !m_tvalid || m_tready;

  // next output word
  logic [OUT_BYTES*8-1:0] out_word;
  logic [1:0]             out_kind;
  logic                   out_last;

  always_comb begin
    out_word          = '0;
    out_word[117:113] = 5'(count);
    out_word[149:118] = pings;
    out_word[181:150] = pongs;
    out_kind          = KIND_DONE;
    out_last          = 1'b1;
    if (stat.ping_left) begin
      out_kind           = KIND_PING;
      out_last           = 1'b0;
      out_word[31:0]     = t_ip[ri];
      out_word[47:32]    = t_port[ri];
      out_word[48 +: NB] = t_non[ri];
    end else if (func == FN_PONG) begin
      out_kind      = flag ? KIND_ACC : KIND_REJ;
      out_word[112] = flag;
    end else begin
      out_word[112] = (func == FN_ADD) && flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval   <= 32'd25000;
      timeout    <= 32'd90000;
      limit      <= 8'd3;
      max_act    <= 5'd10;
      count      <= '0;
      rd         <= '0;
      wr         <= '0;
      running    <= 1'b0;
      last_batch <= '0;
      pings      <= '0;
      pongs      <= '0;
      m_tvalid   <= 1'b0;
      walk_en    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INTERVAL: interval <= cfg_data;
          REG_TIMEOUT:  timeout  <= cfg_data;
          REG_LIMIT:    limit    <= cfg_data[7:0];
          REG_MAXACT:   max_act  <= cfg_data[4:0];
          default: ;
        endcase
      end

      if (cmd.emit)                  m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      if (cmd.load) begin
        func  <= s_tuser;
        now   <= in_now;
        ip    <= in_ip;
        port  <= in_port;
        nonce <= in_nonce;
        rd    <= '0;
        wr    <= '0;
        flag  <= 1'b0;
        go    <= 1'b0;
        walk_en <= 1'b0;
        case (s_tuser)
          FN_TICK: begin
            go      <= in_tick_go;
            walk_en <= in_tick_go;
            if (in_tick_go) last_batch <= in_now;
          end
          FN_ADD, FN_RM: walk_en <= 1'b1;
          FN_PONG: begin
            go      <= in_pong_go;
            walk_en <= in_pong_go;
          end
          FN_START: begin
            if (!running) begin
              running    <= 1'b1;
              last_batch <= in_now;
            end
          end
          FN_STOP: running <= 1'b0;
          default: ;
        endcase
      end

      if (cmd.walk) begin
        rd <= rd + CW'(1);
        case (func)
          FN_TICK: begin
            if (!drop) begin
              t_ip[wi]   <= t_ip[ri];
              t_port[wi] <= t_port[ri];
              t_pong[wi] <= t_pong[ri];
              t_miss[wi] <= silent ? miss_inc : t_miss[ri];
              t_ping[wi] <= now;
              t_pend[wi] <= 1'b1;
              t_non[wi]  <= nonce + NB'(wr);
              wr         <= wr + CW'(1);
            end
          end
          FN_ADD: if (kmatch) flag <= 1'b1;
          FN_RM: begin
            if (!kmatch) begin
              t_ip[wi]   <= t_ip[ri];
              t_port[wi] <= t_port[ri];
              t_pong[wi] <= t_pong[ri];
              t_miss[wi] <= t_miss[ri];
              t_ping[wi] <= t_ping[ri];
              t_pend[wi] <= t_pend[ri];
              t_non[wi]  <= t_non[ri];
              wr         <= wr + CW'(1);
            end
          end
          FN_PONG: begin
            if (!flag && pmatch) begin
              t_port[ri] <= port;
              t_pong[ri] <= now;
              t_ping[ri] <= '0;
              t_pend[ri] <= 1'b0;
              t_non[ri]  <= '0;
              t_miss[ri] <= '0;
              flag       <= 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (cmd.finish) begin
        rd <= '0;
        case (func)
          FN_TICK: begin
            if (go) begin
              count <= wr;
              pings <= pings + 32'(wr);
            end
          end
          FN_ADD: begin
            flag <= add_ok;
            if (add_ok) begin
              t_ip[ci]   <= ip;
              t_port[ci] <= port;
              t_non[ci]  <= '0;
              t_ping[ci] <= '0;
              t_pong[ci] <= now;
              t_miss[ci] <= '0;
              t_pend[ci] <= 1'b0;
              count      <= count + CW'(1);
            end
          end
          FN_RM:   count <= wr;
          FN_PONG: if (flag) pongs <= pongs + 32'd1;
          default: ;
        endcase
      end

      if (cmd.emit) begin
        m_tdata <= out_word;
        m_tuser <= out_kind;
        m_tlast <= out_last;
        if (stat.ping_left) rd <= rd + CW'(1);
      end
    end
  end

  a_rd_bound: assert property (@(posedge clk) disable iff (rst)
    rd <= count) else $error("read pointer past table end");
  a_wr_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.walk |-> wr <= rd) else $error("write pointer ahead of read pointer");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SLOTS)) else $error("table overfull");
endmodule
`default_nettype wire

/* hdl/peer_keepalive_liveness_table.sv */
`default_nettype none
// Each item is accepted, walks the table if it is a due tick, an add, a remove or a
// live pong, is committed, then emits its result words; the other items skip the walk.
// One item at a time: no new item is taken until the current one has loaded its last
// result word; a due tick emits a ping word per kept peer first; a held word stalls.
// Reset (rst, synchronous): table empty, stopped, counters zero, registers
// back to 25000 ms interval, 90000 ms timeout, miss limit 3, 10 peers.
module peer_keepalive_liveness_table #(
  parameter int TABLE_SLOTS = 16,
  parameter int NONCE_BITS  = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config write port: 0 interval, 1 timeout, 2 miss limit, 3 max active
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // now_ms[31:0] peer_ip[63:32] peer_port[79:64] nonce[143:80]
  input  wire logic [pklt_pkg::IN_BYTES*8-1:0] s_tdata,
  // func[2:0]
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // dest_ip[31:0] dest_port[47:32] ping_nonce[111:48] accepted[112]
  // active_count[117:113] pings_sent[149:118] pongs_received[181:150]
  output logic [pklt_pkg::OUT_BYTES*8-1:0] m_tdata,
  // kind[1:0]
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);
  import pklt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // controller sequences load, table walk, commit and result emission
  pklt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath holds the table, counters, config and the output word register
  pklt_dp #(
    .SLOTS (TABLE_SLOTS),
    .NB    (NONCE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );
endmodule
`default_nettype wire
